// ===== rtl/lqrc_pkg.sv =====
`timescale 1ns / 1ps

package lqrc_pkg;

  // Event codes carried in the op field
  typedef enum logic [2:0] {
    OP_TRIGGER     = 3'd0,
    OP_EXPECT_PUSH = 3'd1,
    OP_POLL        = 3'd2,
    OP_START       = 3'd3,
    OP_END         = 3'd4
  } op_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_TMO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RETRY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LIM = 3'd3;

  // Register reset values
  localparam logic [15:0] RESP_TMO_RST   = 16'd1500;
  localparam logic [3:0]  RETRY_LIM_RST  = 4'd2;
  localparam logic [15:0] IDLE_RETRY_RST = 16'd2500;
  localparam logic [19:0] STREAM_LIM_RST = 20'd60000;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic        boot_done;
    logic        main_page_on;
    logic        send_accepted;
  } in_item_t;

  typedef struct packed {
    logic       send_request;
    logic       accepts_data;
    logic       pending_flag;
    logic       started_flag;
    logic       complete_flag;
    logic       failed_flag;
    logic       expired_flag;
    logic       deferred_flag;
    logic [3:0] retries_used;
    logic       event_accepted;
  } out_item_t;

  // Decoded event class, at most one bit set (none for unknown codes)
  typedef struct packed {
    logic is_trigger;
    logic is_push;
    logic is_poll;
    logic is_start;
    logic is_end;
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [31:0] now_ms;
    logic        boot_done;
    logic        main_page_on;
    logic        send_accepted;
  } ev_item_t;

endpackage

// ===== rtl/lqrc_front.sv =====
`timescale 1ns / 1ps

module lqrc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lqrc_pkg::in_item_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output lqrc_pkg::ev_item_t  q_wdata
);
  import lqrc_pkg::*;

  ev_item_t ev_r, ev_nxt;
  logic     valid_r, valid_nxt;
  logic     accept;

  assign q_push   = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = ev_r;

  // Classify the incoming event
  always_comb begin
    ev_nxt = '0;
    case (op_t'(in_data.op))
      OP_TRIGGER:     ev_nxt.kind.is_trigger = 1'b1;
      OP_EXPECT_PUSH: ev_nxt.kind.is_push    = 1'b1;
      OP_POLL:        ev_nxt.kind.is_poll    = 1'b1;
      OP_START:       ev_nxt.kind.is_start   = 1'b1;
      OP_END:         ev_nxt.kind.is_end     = 1'b1;
      default:        ev_nxt.kind            = '0;
    endcase
    ev_nxt.now_ms        = in_data.now_ms;
    ev_nxt.boot_done     = in_data.boot_done;
    ev_nxt.main_page_on  = in_data.main_page_on;
    ev_nxt.send_accepted = in_data.send_accepted;
  end

  // Holding stage valid
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r <= ev_nxt;
    end
  end

endmodule

// ===== rtl/lqrc_queue.sv =====
`timescale 1ns / 1ps

module lqrc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lqrc_pkg::ev_item_t  wdata,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output lqrc_pkg::ev_item_t  rdata
);
  import lqrc_pkg::*;

  ev_item_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/lqrc_back.sv =====
`timescale 1ns / 1ps

module lqrc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  lqrc_pkg::ev_item_t                q_rdata,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lqrc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lqrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lqrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lqrc_pkg::*;

  // Configuration
  logic [15:0] resp_tmo_r;
  logic [3:0]  retry_lim_r;
  logic [15:0] idle_retry_r;
  logic [19:0] stream_lim_r;

  // Query state
  logic        pend_r, pend_nxt;
  logic        strt_r, strt_nxt;
  logic        cmpl_r, cmpl_nxt;
  logic        fail_r, fail_nxt;
  logic        expd_r, expd_nxt;
  logic        dfrd_r, dfrd_nxt;
  logic        wpush_r, wpush_nxt;
  logic [3:0]  rcnt_r, rcnt_nxt;
  logic [31:0] req_t_r, req_t_nxt;
  logic [31:0] act_t_r, act_t_nxt;
  logic [31:0] idle_t_r, idle_t_nxt;

  out_item_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic        snd;
  logic        ev;
  logic        done;
  ev_item_t    it;

  // Wrap-safe interval check
  function automatic logic elapsed(input logic [31:0] t_now, input logic [31:0] since,
                                   input logic [19:0] ival);
    logic [31:0] d;
    d = t_now - since;
    return !d[31] && (d >= {12'd0, ival});
  endfunction

  assign cfg_ready = 1'b1;
  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign it        = q_rdata;

  // Event execution
  always_comb begin
    pend_nxt   = pend_r;
    strt_nxt   = strt_r;
    cmpl_nxt   = cmpl_r;
    fail_nxt   = fail_r;
    expd_nxt   = expd_r;
    dfrd_nxt   = dfrd_r;
    wpush_nxt  = wpush_r;
    rcnt_nxt   = rcnt_r;
    req_t_nxt  = req_t_r;
    act_t_nxt  = act_t_r;
    idle_t_nxt = idle_t_r;
    snd        = 1'b0;
    ev         = 1'b0;
    done       = 1'b0;

    if (it.kind.is_trigger) begin
      rcnt_nxt  = '0;
      wpush_nxt = 1'b0;
      fail_nxt  = 1'b0;
      expd_nxt  = 1'b0;
      pend_nxt  = 1'b0;
      strt_nxt  = 1'b0;
      cmpl_nxt  = 1'b0;
      dfrd_nxt  = !it.boot_done;
      snd       = it.boot_done;
    end

    if (it.kind.is_push) begin
      rcnt_nxt  = '0;
      fail_nxt  = 1'b0;
      expd_nxt  = 1'b0;
      strt_nxt  = 1'b0;
      cmpl_nxt  = 1'b0;
      wpush_nxt = 1'b1;
      pend_nxt  = 1'b1;
      dfrd_nxt  = !it.boot_done;
      req_t_nxt = it.now_ms;
      act_t_nxt = it.now_ms;
    end

    if (it.kind.is_poll) begin
      // deferred push: hold until boot, then restart the silence window
      if (dfrd_r && wpush_r) begin
        if (!it.boot_done) begin
          done = 1'b1;
        end else begin
          dfrd_nxt = 1'b0;
          if (!strt_r && !cmpl_r && !fail_r) begin
            req_t_nxt = it.now_ms;
            act_t_nxt = it.now_ms;
          end
        end
      end
      if (!done && pend_r && expd_r) begin
        done = 1'b1;
      end
      // stream silence or total length exceeded
      if (!done && pend_r && strt_r &&
          (elapsed(it.now_ms, act_t_nxt, {4'd0, resp_tmo_r}) ||
           elapsed(it.now_ms, req_t_nxt, stream_lim_r))) begin
        expd_nxt = 1'b1;
        fail_nxt = 1'b1;
        done     = 1'b1;
      end
      // no response started in time
      if (!done && pend_r && !strt_r &&
          elapsed(it.now_ms, req_t_nxt, {4'd0, resp_tmo_r})) begin
        done = 1'b1;
        if (wpush_r) begin
          snd = 1'b1;
        end else if (rcnt_r < retry_lim_r) begin
          pend_nxt = 1'b0;
          strt_nxt = 1'b0;
          rcnt_nxt = rcnt_r + 4'd1;
          snd      = 1'b1;
        end else begin
          strt_nxt   = 1'b0;
          idle_t_nxt = it.now_ms;
          pend_nxt   = 1'b1;
          expd_nxt   = 1'b1;
          fail_nxt   = 1'b1;
        end
      end
      // deferred trigger released by boot
      if (!done && dfrd_nxt && !pend_r && it.boot_done) begin
        done     = 1'b1;
        dfrd_nxt = 1'b0;
        snd      = 1'b1;
      end
      // idle retry on the main page
      if (!done && !pend_r && !cmpl_r && !fail_r && it.main_page_on &&
          it.boot_done && elapsed(it.now_ms, idle_t_r, {4'd0, idle_retry_r})) begin
        rcnt_nxt = '0;
        snd      = 1'b1;
      end
    end

    if (it.kind.is_start && pend_r) begin
      ev = 1'b1;
      if (!expd_r) begin
        strt_nxt  = 1'b1;
        act_t_nxt = it.now_ms;
      end
    end

    if (it.kind.is_end) begin
      pend_nxt = 1'b0;
      if (pend_r && strt_r && !expd_r) begin
        cmpl_nxt = 1'b1;
        rcnt_nxt = '0;
      end else if (pend_r) begin
        cmpl_nxt   = 1'b0;
        fail_nxt   = 1'b1;
        idle_t_nxt = req_t_r;
      end
      strt_nxt = 1'b0;
      expd_nxt = 1'b0;
      ev       = pend_r;
    end

    // request issued this step
    if (snd) begin
      req_t_nxt  = it.now_ms;
      act_t_nxt  = it.now_ms;
      idle_t_nxt = it.now_ms;
      wpush_nxt  = 1'b0;
      strt_nxt   = 1'b0;
      cmpl_nxt   = 1'b0;
      pend_nxt   = it.send_accepted;
      if (!it.send_accepted) begin
        fail_nxt = 1'b1;
      end
    end

    res_nxt.send_request   = snd;
    res_nxt.accepts_data   = !expd_nxt && (!pend_nxt || strt_nxt);
    res_nxt.pending_flag   = pend_nxt;
    res_nxt.started_flag   = strt_nxt;
    res_nxt.complete_flag  = cmpl_nxt;
    res_nxt.failed_flag    = fail_nxt;
    res_nxt.expired_flag   = expd_nxt;
    res_nxt.deferred_flag  = dfrd_nxt;
    res_nxt.retries_used   = rcnt_nxt;
    res_nxt.event_accepted = ev;
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      strt_r      <= 1'b0;
      cmpl_r      <= 1'b0;
      fail_r      <= 1'b0;
      expd_r      <= 1'b0;
      dfrd_r      <= 1'b0;
      wpush_r     <= 1'b0;
      rcnt_r      <= '0;
      req_t_r     <= '0;
      act_t_r     <= '0;
      idle_t_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        pend_r   <= pend_nxt;
        strt_r   <= strt_nxt;
        cmpl_r   <= cmpl_nxt;
        fail_r   <= fail_nxt;
        expd_r   <= expd_nxt;
        dfrd_r   <= dfrd_nxt;
        wpush_r  <= wpush_nxt;
        rcnt_r   <= rcnt_nxt;
        req_t_r  <= req_t_nxt;
        act_t_r  <= act_t_nxt;
        idle_t_r <= idle_t_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_tmo_r   <= RESP_TMO_RST;
      retry_lim_r  <= RETRY_LIM_RST;
      idle_retry_r <= IDLE_RETRY_RST;
      stream_lim_r <= STREAM_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESP_TMO:   resp_tmo_r   <= cfg_wdata[15:0];
        CFG_RETRY_LIM:  retry_lim_r  <= cfg_wdata[3:0];
        CFG_IDLE_RETRY: idle_retry_r <= cfg_wdata[15:0];
        CFG_STREAM_LIM: stream_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Expired only ever stands on a pending, failed query
  a_expired_implies: assert property (@(posedge clk) disable iff (!rst_n)
    expd_r |-> (pend_r && fail_r))
    else $error("expired without pending and failed");

  // A completed query is never still pending
  a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmpl_r |-> !pend_r)
    else $error("complete while pending");

  // A sent request restarts all three timestamps together
  a_send_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && snd) |=> (req_t_r == act_t_r && act_t_r == idle_t_r))
    else $error("timestamps differ after send");

  // Every executed event shows up in the output register
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid_r)
    else $error("executed event lost");

endmodule

// ===== rtl/list_query_retry_controller_top.sv =====
`timescale 1ns / 1ps

// List query retry controller. Takes one event per clock while not stalled
// (trigger, expect push, poll, response start, response end) and returns
// one status result per event, in order. An accepted event passes a decode
// register, a four-entry queue and the execution stage, whose output register
// holds the result; sustained rate is one event per cycle while out_stall is
// low, set by the execution stage, which updates the query flags and does its
// four wrap-safe timestamp checks. The output register and the queue absorb
// a stalled result while new events keep coming in.
// Configuration writes are taken at any time on the cfg port (always ready)
// and should be made only while no event is in flight. No clearing pass is
// needed after reset.
module list_query_retry_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lqrc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lqrc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lqrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lqrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lqrc_pkg::*;

  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  ev_item_t q_wdata;
  ev_item_t q_rdata;

  // Decode front end
  lqrc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Event queue
  lqrc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // Execution and output register
  lqrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
